// ===== sv/wdavg_pkg.sv =====
// Package for the windowed duration average block.
// Holds the fixed field widths and counter limits shared by the design.
// Depends on nothing.
`default_nettype none

package wdavg_pkg;

    // Width of a duration and of the mean.
    localparam int DATA_W = 32;

    // Width of the written window length and the samples-held field.
    localparam int LEN_W = 7;

    // Window length after reset, before clamping to the store depth.
    localparam int LEN_RESET = 64;

    // Saturation value of the update counter.
    localparam logic [DATA_W-1:0] COUNT_MAX = {DATA_W{1'b1}};

endpackage : wdavg_pkg

`default_nettype wire

// ===== sv/windowed_duration_average.sv =====
// Moving average of durations over a window held in a ring store.
// The mean is computed by a bit-serial restoring divider; a new item is
// accepted only after the previous result has been loaded into the result
// register and the sequencer has returned to idle.
// Reset clears the window, the sum and the update count; the window length
// returns to 64, clamped to WINDOW_MAX. The ring store is not cleared.
`default_nettype none

module windowed_duration_average
    import wdavg_pkg::*;
#(
    parameter int WINDOW_MAX = 64
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    // Configuration channel.
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [LEN_W-1:0]  window_len,
    // Input channel.
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [DATA_W-1:0] duration_ms,
    // Result channel.
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic [DATA_W-1:0]      average_ms,
    output logic [LEN_W-1:0]       samples_held,
    output logic [DATA_W-1:0]      total_updates
);

    // Derived widths.
    localparam int IDX_W   = $clog2(WINDOW_MAX);
    localparam int CNT_W   = $clog2(WINDOW_MAX + 1);
    localparam int SUM_W   = DATA_W + IDX_W;
    localparam int REM_W   = CNT_W + 1;
    localparam int STEP_W  = $clog2(SUM_W);
    localparam int LEN_RST = (LEN_RESET > WINDOW_MAX) ? WINDOW_MAX : LEN_RESET;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_SUB,
        S_ADD,
        S_DIV,
        S_DONE
    } state_t;

    state_t              state_reg, state_next;
    logic [CNT_W-1:0]    len_reg, len_next;
    logic [CNT_W-1:0]    fill_reg, fill_next;
    logic [IDX_W-1:0]    oldest_reg, oldest_next;
    logic [SUM_W-1:0]    sum_reg, sum_next;
    logic [DATA_W-1:0]   count_reg, count_next;
    logic [DATA_W-1:0]   dur_reg, dur_next;
    logic [IDX_W-1:0]    slot_reg, slot_next;
    logic                full_reg, full_next;
    logic [SUM_W-1:0]    quot_reg, quot_next;
    logic [CNT_W-1:0]    rem_reg, rem_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic                out_valid_reg, out_valid_next;
    logic [DATA_W-1:0]   avg_reg, avg_next;
    logic [LEN_W-1:0]    held_reg, held_next;
    logic [DATA_W-1:0]   total_reg, total_next;
    logic [DATA_W-1:0]   rd_reg;

    // Ring store of held durations.
    logic [DATA_W-1:0]   window_mem [WINDOW_MAX];

    logic                cfg_fire;
    logic                in_fire;
    logic [DATA_W-1:0]   len_ext;
    logic [CNT_W-1:0]    len_clamped;
    logic [CNT_W:0]      slot_sum;
    logic [CNT_W:0]      slot_wrap;
    logic [CNT_W:0]      oldest_inc;
    logic [REM_W-1:0]    trial;
    logic [REM_W:0]      diff;
    logic [SUM_W-1:0]    sum_add;

    assign cfg_ready     = (state_reg == S_IDLE);
    assign in_ready      = (state_reg == S_IDLE) && !cfg_valid;
    assign cfg_fire      = cfg_valid && cfg_ready;
    assign in_fire       = in_valid && in_ready;
    assign out_valid     = out_valid_reg;
    assign average_ms    = avg_reg;
    assign samples_held  = held_reg;
    assign total_updates = total_reg;

    // Clamp the written window length to the range 1 to WINDOW_MAX.
    always_comb
    begin
        len_ext = DATA_W'(window_len);
        if (len_ext == '0)
        begin
            len_clamped = CNT_W'(1);
        end
        else if (len_ext > DATA_W'(WINDOW_MAX))
        begin
            len_clamped = CNT_W'(WINDOW_MAX);
        end
        else
        begin
            len_clamped = CNT_W'(window_len);
        end
    end

    // Slot for a new value while the window is filling, wrapped once.
    assign slot_sum  = (CNT_W + 1)'(oldest_reg) + (CNT_W + 1)'(fill_reg);
    assign slot_wrap = (slot_sum >= (CNT_W + 1)'(len_reg))
                       ? slot_sum - (CNT_W + 1)'(len_reg) : slot_sum;
    assign oldest_inc = (CNT_W + 1)'(oldest_reg) + (CNT_W + 1)'(1);

    // One restoring divider step: shift in the next dividend bit and trial subtract.
    assign trial   = {rem_reg, quot_reg[SUM_W-1]};
    assign diff    = (REM_W + 1)'(trial) - (REM_W + 1)'(fill_reg);
    assign sum_add = sum_reg + SUM_W'(dur_reg);

    // Sequencer and next-state logic.
    always_comb
    begin
        state_next     = state_reg;
        len_next       = len_reg;
        fill_next      = fill_reg;
        oldest_next    = oldest_reg;
        sum_next       = sum_reg;
        count_next     = count_reg;
        dur_next       = dur_reg;
        slot_next      = slot_reg;
        full_next      = full_reg;
        quot_next      = quot_reg;
        rem_next       = rem_reg;
        step_next      = step_reg;
        avg_next       = avg_reg;
        held_next      = held_reg;
        total_next     = total_reg;
        out_valid_next = out_valid_reg && !out_ready;

        case (state_reg)
            S_IDLE:
            begin
                if (cfg_fire)
                begin
                    // A new window length starts an empty window.
                    len_next    = len_clamped;
                    fill_next   = '0;
                    oldest_next = '0;
                    sum_next    = '0;
                end
                else if (in_fire)
                begin
                    dur_next   = duration_ms;
                    full_next  = (fill_reg >= len_reg);
                    slot_next  = (fill_reg >= len_reg) ? oldest_reg : IDX_W'(slot_wrap);
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                // The store read of the outgoing value happens this cycle.
                state_next = S_SUB;
            end
            S_SUB:
            begin
                if (full_reg)
                begin
                    sum_next = sum_reg - SUM_W'(rd_reg);
                end
                state_next = S_ADD;
            end
            S_ADD:
            begin
                sum_next  = sum_add;
                quot_next = sum_add;
                rem_next  = '0;
                step_next = STEP_W'(SUM_W - 1);
                if (full_reg)
                begin
                    oldest_next = (oldest_inc >= (CNT_W + 1)'(len_reg))
                                  ? '0 : IDX_W'(oldest_inc);
                end
                else
                begin
                    fill_next = fill_reg + CNT_W'(1);
                end
                if (count_reg != COUNT_MAX)
                begin
                    count_next = count_reg + DATA_W'(1);
                end
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (!diff[REM_W])
                begin
                    rem_next  = CNT_W'(diff);
                    quot_next = {quot_reg[SUM_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next  = CNT_W'(trial);
                    quot_next = {quot_reg[SUM_W-2:0], 1'b0};
                end
                step_next = step_reg - STEP_W'(1);
                if (step_reg == '0)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                // Load the result register once the previous result is taken.
                if (!out_valid_reg || out_ready)
                begin
                    avg_next       = quot_reg[DATA_W-1:0];
                    held_next      = LEN_W'(fill_reg);
                    total_next     = count_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            len_reg       <= CNT_W'(LEN_RST);
            fill_reg      <= '0;
            oldest_reg    <= '0;
            sum_reg       <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            len_reg       <= len_next;
            fill_reg      <= fill_next;
            oldest_reg    <= oldest_next;
            sum_reg       <= sum_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Datapath registers without reset.
    always_ff @(posedge clk)
    begin
        dur_reg   <= dur_next;
        slot_reg  <= slot_next;
        full_reg  <= full_next;
        quot_reg  <= quot_next;
        rem_reg   <= rem_next;
        step_reg  <= step_next;
        avg_reg   <= avg_next;
        held_reg  <= held_next;
        total_reg <= total_next;
    end

    // Ring store: registered read of the outgoing value, then write of the new one.
    always_ff @(posedge clk)
    begin
        if (state_reg == S_READ)
        begin
            rd_reg <= window_mem[slot_reg];
        end
        if (state_reg == S_SUB)
        begin
            window_mem[slot_reg] <= dur_reg;
        end
    end

    // The window never holds more values than its length.
    assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= len_reg)
        else $error("fill count exceeds window length");

    // The oldest slot always lies inside the window.
    assert property (@(posedge clk) disable iff (!rst_n)
        CNT_W'(oldest_reg) < len_reg)
        else $error("oldest slot outside window");

    // An accepted item starts the sequencer.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> state_reg == S_READ)
        else $error("input transaction did not start processing");

    // Every new result reports at least one held value.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && state_next == S_IDLE) |=> (out_valid && samples_held != '0))
        else $error("result issued with an empty window");

    // Configuration and input are never taken in the same cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        !(cfg_fire && in_fire))
        else $error("configuration and input transaction collide");

endmodule : windowed_duration_average

`default_nettype wire

// ===== tb/windowed_duration_average_checker.sv =====
// Checker for the windowed duration average block: watches the configuration,
// input and result channels, predicts every result and compares it.
// Depends on wdavg_pkg for the field widths and the counter limit.
`default_nettype none

module windowed_duration_average_checker
    import wdavg_pkg::*;
#(
    parameter int WINDOW_MAX = 64
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_valid,
    input  wire logic              cfg_ready,
    input  wire logic [LEN_W-1:0]  window_len,
    input  wire logic              in_valid,
    input  wire logic              in_ready,
    input  wire logic [DATA_W-1:0] duration_ms,
    input  wire logic              out_valid,
    input  wire logic              out_ready,
    input  wire logic [DATA_W-1:0] average_ms,
    input  wire logic [LEN_W-1:0]  samples_held,
    input  wire logic [DATA_W-1:0] total_updates,
    output int                     mismatch_count,
    output int                     pending_count,
    output int                     result_count
);

    // Depth of the ring of expected results; the block never has more than
    // two transactions outstanding.
    localparam int RING_DEPTH = 8;

    // One result transaction as the block should present it.
    typedef struct packed {
        logic [DATA_W-1:0] average;
        logic [LEN_W-1:0]  held;
        logic [DATA_W-1:0] updates;
    } mean_result_t;

    // Shadow copy of the window and its bookkeeping.
    logic [DATA_W-1:0] window_copy [WINDOW_MAX];
    int unsigned       oldest;
    int unsigned       fill;
    int unsigned       active_len;
    logic [63:0]       sum_acc;
    logic [DATA_W-1:0] updates_seen;
    mean_result_t      expected_ring [RING_DEPTH];
    int unsigned       ring_wr;
    int unsigned       ring_rd;
    int                errors;
    int                results;

    // A written length of zero acts as one; anything above the store depth
    // acts as the store depth.
    function automatic int unsigned clamp_window(input logic [LEN_W-1:0] v);
        if (v == '0)
            return 1;
        if (v > WINDOW_MAX)
            return WINDOW_MAX;
        return 32'(v);
    endfunction

    // Put one duration into the window and work out the mean that follows.
    task automatic absorb_duration(input logic [DATA_W-1:0] d, output mean_result_t r);
        int unsigned slot;
        logic [63:0] quotient;
        if (oldest >= active_len)
            oldest = 0;
        if (fill > active_len)
            fill = active_len;
        if (fill >= active_len) begin
            // Full window: the oldest value leaves and the new one takes its slot.
            slot = oldest;
            sum_acc -= window_copy[slot];
            window_copy[slot] = d;
            oldest = (slot + 1 >= active_len) ? 0 : slot + 1;
        end
        else begin
            slot = oldest + fill;
            if (slot >= active_len)
                slot -= active_len;
            window_copy[slot] = d;
            fill++;
        end
        sum_acc += d;
        if (updates_seen != COUNT_MAX)
            updates_seen++;
        quotient = sum_acc / fill;
        r.average = quotient[DATA_W-1:0];
        r.held    = fill[LEN_W-1:0];
        r.updates = updates_seen;
    endtask

    task automatic flag_error(input string detail);
        errors++;
        if (errors <= 10)
            $display("[%0t] mismatch: %s", $time, detail);
    endtask

    // Watch all three channels at every rising edge.
    always @(posedge clk or negedge rst_n)
    begin : monitor
        mean_result_t seen;
        mean_result_t want;
        if (!rst_n) begin
            oldest         = 0;
            fill           = 0;
            sum_acc        = '0;
            updates_seen   = '0;
            active_len     = clamp_window(LEN_W'(LEN_RESET));
            errors         = 0;
            results        = 0;
            ring_wr        = 0;
            ring_rd        = 0;
            mismatch_count <= 0;
            pending_count  <= 0;
            result_count   <= 0;
        end
        else begin
            // A register write clears the window but keeps the update count.
            if (cfg_valid && cfg_ready) begin
                active_len = clamp_window(window_len);
                oldest     = 0;
                fill       = 0;
                sum_acc    = '0;
            end

            // A result transaction is matched against the oldest expectation.
            if (out_valid && out_ready) begin
                seen = '{average_ms, samples_held, total_updates};
                results++;
                if (ring_wr == ring_rd) begin
                    flag_error($sformatf("unexpected result average=%0d held=%0d updates=%0d",
                                         seen.average, seen.held, seen.updates));
                end
                else begin
                    want = expected_ring[ring_rd % RING_DEPTH];
                    ring_rd++;
                    if (seen.average !== want.average || seen.held !== want.held ||
                        seen.updates !== want.updates)
                        flag_error($sformatf(
                            "average %0d/%0d held %0d/%0d updates %0d/%0d (expected/actual)",
                            want.average, seen.average, want.held, seen.held,
                            want.updates, seen.updates));
                end
            end

            // Each accepted duration leads to exactly one result.
            if (in_valid && in_ready) begin
                absorb_duration(duration_ms, want);
                if (ring_wr - ring_rd >= RING_DEPTH) begin
                    flag_error("more transactions outstanding than the block can hold");
                end
                else begin
                    expected_ring[ring_wr % RING_DEPTH] = want;
                    ring_wr++;
                end
            end

            mismatch_count <= errors;
            pending_count  <= int'(ring_wr - ring_rd);
            result_count   <= results;
        end
    end

endmodule : windowed_duration_average_checker

`default_nettype wire

// ===== tb/windowed_duration_average_tb.sv =====
// Top of the windowed duration average testbench: clock, reset, stimulus and verdict.
// Depends on wdavg_pkg, the windowed_duration_average block and
// windowed_duration_average_checker, which predicts and compares the results.
`default_nettype none

module windowed_duration_average_tb
    import wdavg_pkg::*;
();

    localparam int WINDOW_MAX     = 64;
    localparam int CLK_PERIOD     = 20;
    localparam int RANDOM_ITEMS   = 1750;
    localparam int SETTLE_CYCLES  = 60;
    localparam int TIMEOUT_CYCLES = 1_500_000;

    logic              clk         = 1'b0;
    logic              rst_n       = 1'b0;
    logic              cfg_valid   = 1'b0;
    logic              cfg_ready;
    logic [LEN_W-1:0]  window_len  = '0;
    logic              in_valid    = 1'b0;
    logic              in_ready;
    logic [DATA_W-1:0] duration_ms = '0;
    logic              out_valid;
    logic              out_ready   = 1'b0;
    logic [DATA_W-1:0] average_ms;
    logic [LEN_W-1:0]  samples_held;
    logic [DATA_W-1:0] total_updates;

    int mismatches;
    int pending;
    int results;
    int send_idle_pct     = 0;
    int recv_idle_pct     = 0;
    int settings_written  = 0;
    int durations_sent    = 0;

    always #(CLK_PERIOD / 2) clk = ~clk;

    windowed_duration_average #(
        .WINDOW_MAX(WINDOW_MAX)
    ) i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .window_len   (window_len),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .duration_ms  (duration_ms),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .average_ms   (average_ms),
        .samples_held (samples_held),
        .total_updates(total_updates)
    );

    windowed_duration_average_checker #(
        .WINDOW_MAX(WINDOW_MAX)
    ) i_mean_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .window_len    (window_len),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .duration_ms   (duration_ms),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .average_ms    (average_ms),
        .samples_held  (samples_held),
        .total_updates (total_updates),
        .mismatch_count(mismatches),
        .pending_count (pending),
        .result_count  (results)
    );

    // The receiver stalls at random, at the rate of the current phase.
    always @(posedge clk)
    begin
        out_ready <= rst_n && ($urandom_range(99) >= recv_idle_pct);
    end

    // Offer one duration, with a random gap first, and wait for its transaction.
    task automatic send_duration(input logic [DATA_W-1:0] d);
        if ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < send_idle_pct)
                @(posedge clk);
        end
        in_valid    <= 1'b1;
        duration_ms <= d;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        durations_sent++;
    endtask

    // Hold the sender off until every expected result has come back.
    task automatic drain_results();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
    endtask

    // Write the window length once the block has nothing in flight.
    task automatic write_window(input logic [LEN_W-1:0] v);
        drain_results();
        cfg_valid  <= 1'b1;
        window_len <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        settings_written++;
    endtask

    // Durations lean toward zero, small values and the top of the range.
    function automatic logic [DATA_W-1:0] pick_duration(input int max_bias_pct);
        int unsigned sel;
        sel = $urandom_range(99);
        if (sel < max_bias_pct)
            return {DATA_W{1'b1}} - $urandom_range(3);
        sel = $urandom_range(99);
        if (sel < 15)
            return '0;
        if (sel < 45)
            return $urandom_range(5000);
        return $urandom();
    endfunction

    // Window lengths include zero, one, the store depth and values beyond it.
    function automatic logic [LEN_W-1:0] pick_window_len();
        case ($urandom_range(7))
            0:       return '0;
            1:       return LEN_W'(1);
            2:       return LEN_W'(WINDOW_MAX);
            3:       return {LEN_W{1'b1}};
            4:       return LEN_W'(WINDOW_MAX + 1 + $urandom_range(62));
            default: return LEN_W'(1 + $urandom_range(WINDOW_MAX - 1));
        endcase
    endfunction

    // Main stimulus sequence.
    initial
    begin : stimulus
        int phase;
        int phase_items;
        int seg_items;
        int max_bias;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: reset length, extremes of the duration, and every
        // way the length register can be clamped.
        send_duration('0);
        send_duration({DATA_W{1'b1}});
        send_duration(1);
        send_duration(32'h8000_0000);
        send_duration(32'h7FFF_FFFF);
        write_window(LEN_W'(1));
        send_duration({DATA_W{1'b1}});
        send_duration('0);
        send_duration(5);
        write_window('0);
        send_duration(32'h5555_5555);
        send_duration(32'hAAAA_AAAA);
        write_window({LEN_W{1'b1}});
        send_duration({DATA_W{1'b1}});
        send_duration(7);
        write_window(LEN_W'(WINDOW_MAX + 1));
        send_duration(3);
        write_window(LEN_W'(2));
        send_duration({DATA_W{1'b1}});
        send_duration({DATA_W{1'b1}});
        send_duration({DATA_W{1'b1}});
        send_duration(0);

        // Random part in three phases of idling: sender light and receiver
        // heavy, then the reverse, then no idling at all.
        for (phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 28 : (phase == 1) ? 80 : 0;
            recv_idle_pct = (phase == 0) ? 80 : (phase == 1) ? 28 : 0;
            phase_items = 0;
            while (phase_items < RANDOM_ITEMS / 3) begin
                write_window(pick_window_len());
                // Some segments fill the window with near-maximum durations
                // to push the running sum to its top.
                max_bias  = ($urandom_range(3) == 0) ? 90 : 20;
                seg_items = $urandom_range(20, 200);
                if (seg_items > RANDOM_ITEMS / 3 - phase_items)
                    seg_items = RANDOM_ITEMS / 3 - phase_items;
                repeat (seg_items) begin
                    if ($urandom_range(199) == 0)
                        drain_results();
                    send_duration(pick_duration(max_bias));
                end
                phase_items += seg_items;
            end
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Run sent %0d durations and checked %0d results over %0d window settings,",
                 durations_sent, results, settings_written);
        $display("including zero, one, full and over-range lengths under three stall patterns.");
        if (mismatches == 0 && pending == 0)
            $display("windowed_duration_average_tb: PASS");
        else
            $display("windowed_duration_average_tb: FAIL");
        $finish;
    end

    // Guard against a hung handshake.
    initial
    begin
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("Timeout with %0d results still expected.", pending);
        $display("windowed_duration_average_tb: FAIL");
        $finish;
    end

endmodule : windowed_duration_average_tb

`default_nettype wire

// ===== filelist.f =====
sv/wdavg_pkg.sv
sv/windowed_duration_average.sv
tb/windowed_duration_average_checker.sv
tb/windowed_duration_average_tb.sv
